// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and codes for the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 16;
  // queue fields wide enough for any list depth up to 65536
  localparam int unsigned QW     = 17;

  typedef enum logic [2:0] {
    CMD_COUNT  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_READ   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_MOVE   = 3'd4,
    CMD_MAX    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ANSWER,
    OP_READ,
    OP_INSERT,
    OP_REMOVE,
    OP_MOVE,
    OP_MAX
  } back_op_t;

  typedef struct packed {
    back_op_t          op;
    logic [QW-1:0]     pos;
    logic [QW-1:0]     cnt;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic idle;
    logic pop;
  } back_stat_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RDRD,
    B_RDOUT,
    B_MVRD,
    B_MVLD,
    B_SHRD,
    B_SHWR,
    B_FINW,
    B_MXRD,
    B_MXCMP
  } bstate_t;

endpackage

// ===== rtl/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// ordered list of signed 32-bit words with insert, read, remove, move-to-end,
// count and maximum commands
// ----------------------------------------------------------------------------
//  channel  | handshake         | word
//  ---------+-------------------+---------------------------
//  command  | start / busy      | cmd, pos, value
//  result   | done (1 cycle)    | answer
//
// the front checks each command against its own running count, so reads past
// the end and the maximum of an empty list are settled at once, and commands
// with bad positions are dropped with no answer; jobs then wait in a two-entry
// queue for the back end; count and settled answers come out once the back end
// takes their job, a read after a memory read; insert, remove and move shift
// one entry at a time (a memory read then a write), maximum reads each entry held
// busy is high only while the queue is full; the receiver cannot stall, done
// marks each answer for exactly one cycle
// rst is synchronous and clears count, queue and sequencer; the entry memory
// is not cleared, since only entries below the count are ever read
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [15:0] pos,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] answer
);
  import ple_pkg::*;

  // memory address width and count width (count can reach DEPTH)
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          take;
  logic          push;
  item_t         item;
  item_t         head;
  logic          q_empty;
  logic          q_full;
  back_stat_t    stat;
  logic [CW-1:0] count;

  // a command is taken whenever the queue has room
  assign busy = q_full;
  assign take = start && !busy;

  ple_front #(.DEPTH(DEPTH), .CW(CW)) u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .cmd   (cmd),
    .pos   (pos),
    .value (value),
    .push  (push),
    .item  (item),
    .count (count)
  );

  ple_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item),
    .pop   (stat.pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  ple_back #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .stat   (stat),
    .done   (done),
    .answer (answer)
  );

`ifndef SYNTH
  // the running count never passes the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} <= (CW+1)'(DEPTH))
    else $error("list count beyond depth");

  // no answer appears out of nowhere: idle back end with empty queue stays quiet
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    stat.idle && q_empty |=> !done)
    else $error("answer without a job");

  // the back end only takes a job while it is idle and one is waiting
  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> stat.idle && !q_empty)
    else $error("queue popped at a bad time");
`endif

endmodule

// ===== rtl/ple_front.sv =====
// ----------------------------------------------------------------------------
// ple_front
// checks each command against the running count and turns it into a job; a command with a bad position is dropped
// ----------------------------------------------------------------------------
module ple_front #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned CW    = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [2:0]           cmd,
  input  logic [15:0]          pos,
  input  logic [31:0]          value,
  output logic                 push,
  output ple_pkg::item_t       item,
  output logic [CW-1:0]        count
);
  import ple_pkg::*;

  logic [CW-1:0] count_next;
  logic          neg;
  logic [QW-1:0] pw;
  logic [QW-1:0] cq;

  assign neg = pos[15];
  assign pw  = QW'(pos[14:0]);
  assign cq  = QW'(count);

  always_comb begin
    push       = 1'b0;
    count_next = count;
    item.op    = OP_ANSWER;
    item.pos   = pw;
    item.cnt   = cq;
    item.data  = value;
    if (take) begin
      unique case (cmd)
        CMD_COUNT: begin
          push      = 1'b1;
          item.data = DATA_W'(count);
        end
        CMD_INSERT: begin
          if (!neg && pw <= cq && cq < QW'(DEPTH)) begin
            push       = 1'b1;
            item.op    = OP_INSERT;
            count_next = count + CW'(1);
          end
        end
        CMD_READ: begin
          if (!neg) begin
            push = 1'b1;
            if (pw >= cq) begin
              item.data = '1;
            end else begin
              item.op = OP_READ;
            end
          end
        end
        CMD_REMOVE: begin
          if (!neg && pw < cq) begin
            push       = 1'b1;
            item.op    = OP_REMOVE;
            count_next = count - CW'(1);
          end
        end
        CMD_MOVE: begin
          if (!neg && pw < cq) begin
            push    = 1'b1;
            item.op = OP_MOVE;
          end
        end
        CMD_MAX: begin
          push = 1'b1;
          if (count == '0) begin
            item.data = '1;
          end else begin
            item.op = OP_MAX;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/ple_queue.sv =====
// ----------------------------------------------------------------------------
// ple_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module ple_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ple_pkg::item_t din,
  input  logic           pop,
  output ple_pkg::item_t head,
  output logic           empty,
  output logic           full
);
  import ple_pkg::*;

  item_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] used;

  assign empty = (used == 2'd0);
  assign full  = (used == 2'd2);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      used <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      used <= used + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/ple_back.sv =====
// ----------------------------------------------------------------------------
// ple_back
// runs list jobs on the entry memory, moving one entry at a time (a read then a write)
// ----------------------------------------------------------------------------
module ple_back #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned CW    = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  ple_pkg::item_t     head,
  input  logic               empty,
  output ple_pkg::back_stat_t stat,
  output logic               done,
  output logic [31:0]        answer
);
  import ple_pkg::*;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          we;

  bstate_t       st, st_next;
  back_op_t      op, op_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] fin, fin_next;
  logic [31:0]   hold, hold_next;
  logic [31:0]   best, best_next;
  logic          done_next;
  logic [31:0]   answer_next;
  logic [31:0]   cand;
  logic [CW-1:0] hp, hc;

  assign hp = head.pos[CW-1:0];
  assign hc = head.cnt[CW-1:0];
  assign cand = (k == '0 || $signed(rdata) > $signed(best)) ? rdata : best;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    st_next     = st;
    op_next     = op;
    k_next      = k;
    p_next      = p;
    cnt_next    = cnt;
    fin_next    = fin;
    hold_next   = hold;
    best_next   = best;
    done_next   = 1'b0;
    answer_next = answer;
    raddr       = p[AW-1:0];
    waddr       = k[AW-1:0];
    wdata       = rdata;
    we          = 1'b0;
    stat.idle   = (st == B_IDLE);
    stat.pop    = 1'b0;
    unique case (st)
      B_IDLE: begin
        if (!empty) begin
          stat.pop  = 1'b1;
          op_next   = head.op;
          p_next    = hp;
          cnt_next  = hc;
          hold_next = head.data;
          unique case (head.op)
            OP_ANSWER: begin
              done_next   = 1'b1;
              answer_next = head.data;
            end
            OP_READ: st_next = B_RDRD;
            OP_INSERT: begin
              fin_next = hp;
              k_next   = hc;
              st_next  = (hc == hp) ? B_FINW : B_SHRD;
            end
            OP_REMOVE: begin
              k_next = hp;
              if (({1'b0, hp} + (CW+1)'(1)) < {1'b0, hc}) begin
                st_next = B_SHRD;
              end
            end
            OP_MOVE: begin
              fin_next = hc - CW'(1);
              st_next  = B_MVRD;
            end
            OP_MAX: begin
              k_next  = '0;
              st_next = B_MXRD;
            end
            default: ;
          endcase
        end
      end
      B_RDRD: st_next = B_RDOUT;
      B_RDOUT: begin
        done_next   = 1'b1;
        answer_next = rdata;
        st_next     = B_IDLE;
      end
      B_MVRD: st_next = B_MVLD;
      B_MVLD: begin
        hold_next = rdata;
        k_next    = p;
        if (({1'b0, p} + (CW+1)'(1)) < {1'b0, cnt}) begin
          st_next = B_SHRD;
        end else begin
          st_next = B_FINW;
        end
      end
      B_SHRD: begin
        raddr   = (op == OP_INSERT) ? AW'(k - CW'(1)) : AW'(k + CW'(1));
        st_next = B_SHWR;
      end
      B_SHWR: begin
        we = 1'b1;
        if (op == OP_INSERT) begin
          k_next  = k - CW'(1);
          st_next = ((k - CW'(1)) == p) ? B_FINW : B_SHRD;
        end else begin
          k_next = k + CW'(1);
          if (({1'b0, k} + (CW+1)'(2)) >= {1'b0, cnt}) begin
            st_next = (op == OP_MOVE) ? B_FINW : B_IDLE;
          end else begin
            st_next = B_SHRD;
          end
        end
      end
      B_FINW: begin
        we      = 1'b1;
        waddr   = fin[AW-1:0];
        wdata   = hold;
        st_next = B_IDLE;
      end
      B_MXRD: begin
        raddr   = k[AW-1:0];
        st_next = B_MXCMP;
      end
      B_MXCMP: begin
        best_next = cand;
        if (({1'b0, k} + (CW+1)'(1)) >= {1'b0, cnt}) begin
          done_next   = 1'b1;
          answer_next = cand;
          st_next     = B_IDLE;
        end else begin
          k_next  = k + CW'(1);
          st_next = B_MXRD;
        end
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= B_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= done_next;
    end
    op     <= op_next;
    k      <= k_next;
    p      <= p_next;
    cnt    <= cnt_next;
    fin    <= fin_next;
    hold   <= hold_next;
    best   <= best_next;
    answer <= answer_next;
  end

endmodule
